FILE: src/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants for the fader sample conditioner
// Register codes, LED bar bounds, and the control structs that pass between
// the sequencer, the divide unit and the ramp generator.
// ----------------------------------------------------------------------------
package fsc_pkg;

   localparam int SAMPLE_W = 12;
   localparam int VOL_W    = 7;
   localparam int CNT_W    = 2;
   localparam int NUM_W    = 16;   // sample + 9*smoothed fits in 16 bits
   localparam int TOTAL_W  = 8;    // ramp length, up to 128 values
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DELTA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SNAP_THR  = 2'd1;

   localparam logic [VOL_W-1:0]    MIN_DELTA_RST = 7'd5;
   localparam logic [SAMPLE_W-1:0] SNAP_THR_RST  = 12'd10;
   localparam logic [VOL_W-1:0]    VOL_MAX       = 7'd127;

   // ceil(2^19 / 10); floor(n * RECIP_10 >> 19) equals n / 10 for n below 2^18
   localparam logic [NUM_W-1:0]    RECIP_10      = 16'd52429;
   localparam int                  RECIP_SHIFT   = 19;

   localparam logic [SAMPLE_W-1:0] BAR_BOUNDS [12] = '{
      12'd75, 12'd175, 12'd575, 12'd1000, 12'd1475, 12'd1850,
      12'd2300, 12'd2700, 12'd3250, 12'd3725, 12'd3950, 12'd4000
   };

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [SAMPLE_W-1:0] quot;
   } div_stat_type;

   typedef struct packed {
      logic                load;
      logic [VOL_W-1:0]    start_vol;
      logic [TOTAL_W-1:0]  total;     // zero means no ramp, status only
      logic                up;
      logic [SAMPLE_W-1:0] bar;
   } ramp_cmd_type;

   typedef struct packed {
      logic busy;
   } ramp_stat_type;

   // bounds are sorted, so LED k is lit exactly when raw is below bound 11-k
   function automatic logic [SAMPLE_W-1:0] bar_of(input logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_W-1:0] m;
      for (int k = 0; k < SAMPLE_W; k++) begin
         m[k] = (raw < BAR_BOUNDS[SAMPLE_W-1-k]);
      end
      return m;
   endfunction

endpackage

FILE: src/fsc_div10.sv
// ----------------------------------------------------------------------------
// fsc_div10: divide by ten
// Reciprocal multiplication in two stages: the numerator is registered, then
// multiplied by the scaled reciprocal and shifted down.
// ----------------------------------------------------------------------------
module fsc_div10 (
   input  logic                 clock,
   input  logic                 reset,
   input  fsc_pkg::div_cmd_type cmd,
   output fsc_pkg::div_stat_type stat
);

   logic                          stage_ff, stage_in;
   logic                          done_ff, done_in;
   logic [fsc_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [fsc_pkg::SAMPLE_W-1:0]  quot_ff, quot_in;
   logic [31:0]                   prod;

   assign prod = 32'(num_ff) * 32'(fsc_pkg::RECIP_10);

   always_comb begin
      stage_in = cmd.start;
      done_in  = stage_ff;
      num_in   = cmd.start ? cmd.numer : num_ff;
      // quotient never exceeds 4095 for the numerators used here
      quot_in  = stage_ff
               ? prod[fsc_pkg::RECIP_SHIFT+fsc_pkg::SAMPLE_W-1:fsc_pkg::RECIP_SHIFT]
               : quot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign stat.done = done_ff;
   assign stat.quot = quot_ff;

endmodule

FILE: src/fsc_ramp_gen.sv
// ----------------------------------------------------------------------------
// fsc_ramp_gen: volume ramp output stage
// Steps through the ramp two volumes per result and holds each result until
// the downstream side takes it.
// ----------------------------------------------------------------------------
module fsc_ramp_gen (
   input  logic                          clock,
   input  logic                          reset,
   input  fsc_pkg::ramp_cmd_type         cmd,
   output fsc_pkg::ramp_stat_type        stat,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fsc_pkg::VOL_W-1:0]     rsp_vol_first,
   output logic [fsc_pkg::VOL_W-1:0]     rsp_vol_second,
   output logic [fsc_pkg::CNT_W-1:0]     rsp_vol_count,
   output logic [fsc_pkg::SAMPLE_W-1:0]  rsp_bar_mask,
   output logic                          rsp_last
);

   logic                          valid_ff, valid_in;
   logic [fsc_pkg::VOL_W-1:0]     cur_ff, cur_in;
   logic [fsc_pkg::TOTAL_W-1:0]   rem_ff, rem_in;
   logic                          up_ff, up_in;
   logic [fsc_pkg::SAMPLE_W-1:0]  bar_ff, bar_in;
   logic                          is_last;
   logic                          two;

   assign is_last = (rem_ff <= 8'd2);
   assign two     = (rem_ff >= 8'd2);

   always_comb begin
      valid_in = valid_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      up_in    = up_ff;
      bar_in   = bar_ff;
      if (cmd.load) begin
         valid_in = 1'b1;
         cur_in   = cmd.start_vol;
         rem_in   = cmd.total;
         up_in    = cmd.up;
         bar_in   = cmd.bar;
      end else if (valid_ff && rsp_ready) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            cur_in = up_ff ? cur_ff + 7'd2 : cur_ff - 7'd2;
            rem_in = rem_ff - 8'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cur_ff <= cur_in;
      rem_ff <= rem_in;
      up_ff  <= up_in;
      bar_ff <= bar_in;
   end

   assign stat.busy      = valid_ff;
   assign rsp_valid      = valid_ff;
   assign rsp_vol_first  = (rem_ff == '0) ? '0 : cur_ff;
   assign rsp_vol_second = !two ? '0 : (up_ff ? cur_ff + 7'd1 : cur_ff - 7'd1);
   assign rsp_vol_count  = (rem_ff == '0) ? 2'd0 : (two ? 2'd2 : 2'd1);
   assign rsp_bar_mask   = bar_ff;
   assign rsp_last       = is_last;

endmodule

FILE: src/fader_sample_conditioner.sv
// ----------------------------------------------------------------------------
// fader_sample_conditioner: fader smoothing, volume ramp and LED bar
// One request in, one or more results out: a volume ramp two steps a result.
// ----------------------------------------------------------------------------
// Flow: on a snap a request goes to ST_VOL and loads the ramp generator; else
//   it waits in ST_DIV for the two-stage divide-by-ten unit that smooths it.
// Throughput: one request at a time; results follow one per cycle while
//   accepted, up to 64, and req_ready returns after the ramp generator goes idle.
// Reset: synchronous; clears state, loads min_delta 5 and snap_threshold 10.
module fader_sample_conditioner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fsc_pkg::SAMPLE_W-1:0]        req_adc_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fsc_pkg::VOL_W-1:0]           rsp_vol_first,
   output logic [fsc_pkg::VOL_W-1:0]           rsp_vol_second,
   output logic [fsc_pkg::CNT_W-1:0]           rsp_vol_count,
   output logic [fsc_pkg::SAMPLE_W-1:0]        rsp_bar_mask,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fsc_pkg::SAMPLE_W-1:0]        csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_VOL  = 4'b0100,
      ST_EMIT = 4'b1000
   } seq_state_type;

   seq_state_type                  state_ff, state_in;
   logic [fsc_pkg::VOL_W-1:0]      min_delta_ff, min_delta_in;
   logic [fsc_pkg::SAMPLE_W-1:0]   snap_thr_ff, snap_thr_in;
   logic [fsc_pkg::SAMPLE_W-1:0]   smoothed_ff, smoothed_in;
   logic [fsc_pkg::VOL_W-1:0]      volume_ff, volume_in;
   logic [fsc_pkg::SAMPLE_W-1:0]   raw_ff, raw_in;

   fsc_pkg::div_cmd_type    div_cmd;
   fsc_pkg::div_stat_type   div_stat;
   fsc_pkg::ramp_cmd_type   ramp_cmd;
   fsc_pkg::ramp_stat_type  ramp_stat;

   logic                          req_fire;
   logic                          snap;
   logic [fsc_pkg::VOL_W-1:0]     new_vol;
   logic                          up;
   logic [fsc_pkg::VOL_W-1:0]     diff;
   logic                          update;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign snap = ({1'b0, req_adc_sample} < ({1'b0, smoothed_ff} + {1'b0, snap_thr_ff}));

   assign new_vol = fsc_pkg::VOL_MAX - smoothed_ff[fsc_pkg::SAMPLE_W-1:5];
   assign up      = (new_vol >= volume_ff);
   assign diff    = up ? new_vol - volume_ff : volume_ff - new_vol;
   assign update  = (diff > min_delta_ff);

   // numerator = sample + 9 * smoothed
   assign div_cmd.start = req_fire && !snap;
   assign div_cmd.numer = {4'b0000, req_adc_sample} + {1'b0, smoothed_ff, 3'b000}
                        + {4'b0000, smoothed_ff};

   always_comb begin
      state_in     = state_ff;
      min_delta_in = min_delta_ff;
      snap_thr_in  = snap_thr_ff;
      smoothed_in  = smoothed_ff;
      volume_in    = volume_ff;
      raw_in       = raw_ff;
      ramp_cmd     = '0;
      if (csr_valid) begin
         case (csr_index)
            fsc_pkg::CSR_MIN_DELTA: min_delta_in = csr_wdata[fsc_pkg::VOL_W-1:0];
            fsc_pkg::CSR_SNAP_THR:  snap_thr_in  = csr_wdata;
            default: ;
         endcase
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (snap) begin
                  smoothed_in = req_adc_sample;
                  state_in    = ST_VOL;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               smoothed_in = div_stat.quot;
               state_in    = ST_VOL;
            end
         end
         ST_VOL: begin
            ramp_cmd.load = 1'b1;
            if (update) begin
               volume_in          = new_vol;
               raw_in             = smoothed_ff;
               ramp_cmd.start_vol = volume_ff;
               ramp_cmd.total     = {1'b0, diff} + 8'd1;
               ramp_cmd.up        = up;
               ramp_cmd.bar       = fsc_pkg::bar_of(smoothed_ff);
            end else begin
               ramp_cmd.bar = fsc_pkg::bar_of(raw_ff);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!ramp_stat.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_delta_ff <= fsc_pkg::MIN_DELTA_RST;
         snap_thr_ff  <= fsc_pkg::SNAP_THR_RST;
         smoothed_ff  <= '0;
         volume_ff    <= '0;
         raw_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         min_delta_ff <= min_delta_in;
         snap_thr_ff  <= snap_thr_in;
         smoothed_ff  <= smoothed_in;
         volume_ff    <= volume_in;
         raw_ff       <= raw_in;
      end
   end

   fsc_div10 u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   fsc_ramp_gen u_ramp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ramp_cmd),
      .stat           (ramp_stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_vol_first  (rsp_vol_first),
      .rsp_vol_second (rsp_vol_second),
      .rsp_vol_count  (rsp_vol_count),
      .rsp_bar_mask   (rsp_bar_mask),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: src/fsc_checker.sv
// ----------------------------------------------------------------------------
// fsc_checker: port-level checks for the fader sample conditioner
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module fsc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [fsc_pkg::VOL_W-1:0]           rsp_vol_first,
   input logic [fsc_pkg::VOL_W-1:0]           rsp_vol_second,
   input logic [fsc_pkg::CNT_W-1:0]           rsp_vol_count,
   input logic [fsc_pkg::SAMPLE_W-1:0]        rsp_bar_mask,
   input logic                                rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vol_first)
         && $stable(rsp_vol_second) && $stable(rsp_vol_count)
         && $stable(rsp_bar_mask) && $stable(rsp_last))
      else $error("result changed while stalled");

   // no new request while results of the previous one are pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request accepted with a result pending");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_vol_count != 2'd3)
      else $error("volume count out of range");

   // status-only and odd-tail results end the sequence
   a_short_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vol_count != 2'd2 |-> rsp_last && rsp_vol_second == '0)
      else $error("short result not marked last");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vol_count == 2'd0 |-> rsp_vol_first == '0)
      else $error("status-only result carries a volume");

endmodule

bind fader_sample_conditioner fsc_checker u_fsc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_vol_first  (rsp_vol_first),
   .rsp_vol_second (rsp_vol_second),
   .rsp_vol_count  (rsp_vol_count),
   .rsp_bar_mask   (rsp_bar_mask),
   .rsp_last       (rsp_last)
);
